[hdl/acc_pkg.sv]
// Shared types, operation codes and constants of the accumulator ALU.
// Used by every module of the block and by its checker; depends on nothing.
package acc_pkg;

   // Operation codes; codes 19 to 31 do nothing
   localparam logic [4:0] OP_OR     = 5'd0;
   localparam logic [4:0] OP_AND    = 5'd1;
   localparam logic [4:0] OP_XOR    = 5'd2;
   localparam logic [4:0] OP_ADC    = 5'd3;
   localparam logic [4:0] OP_SBC    = 5'd4;
   localparam logic [4:0] OP_CMP    = 5'd5;
   localparam logic [4:0] OP_BIT    = 5'd6;
   localparam logic [4:0] OP_ASL    = 5'd7;
   localparam logic [4:0] OP_LSR    = 5'd8;
   localparam logic [4:0] OP_ROL    = 5'd9;
   localparam logic [4:0] OP_ROR    = 5'd10;
   localparam logic [4:0] OP_INC    = 5'd11;
   localparam logic [4:0] OP_DEC    = 5'd12;
   localparam logic [4:0] OP_SWAP   = 5'd13;
   localparam logic [4:0] OP_MUL    = 5'd14;
   localparam logic [4:0] OP_DIV    = 5'd15;
   localparam logic [4:0] OP_SETBIT = 5'd16;
   localparam logic [4:0] OP_CLRBIT = 5'd17;
   localparam logic [4:0] OP_TEST   = 5'd18;

   // Quotient bits worked by the divider, and default bits per stage
   localparam int DIV_BITS          = 16;
   localparam int DIV_STEPS_DEFAULT = 4;

   localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
   localparam logic [3:0] BCD_ADJUST    = 4'd6;

   typedef struct packed {
      logic [4:0] op;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [7:0] dividend_high;
      logic [2:0] bit_index;
      logic       carry_in;
      logic       overflow_in;
      logic       decimal_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [7:0] result_high;
      logic       negative;
      logic       zero;
      logic       carry_out;
      logic       overflow_out;
      logic       writes_nz;
      logic       divide_by_zero;
   } rsp_type;

   // Word carried down the pipeline between the front end and the output stage
   typedef struct packed {
      logic [4:0]  op;
      logic [7:0]  b;
      logic [7:0]  r;
      logic [7:0]  hi;
      logic [7:0]  nzv;
      logic        n;
      logic        z;
      logic        c;
      logic        v;
      logic        wnz;
      logic [15:0] num;
      logic [7:0]  rem;
   } stage_type;

endpackage

[hdl/acc_front.sv]
// Front end of the accumulator ALU: decodes the operation and works every
// non-divide result, the multiply and the divider seed. Depends on acc_pkg.
module acc_front (
   input  acc_pkg::req_type   req,
   output acc_pkg::stage_type stage
);
   import acc_pkg::*;

   logic [4:0]  lo_sum;
   logic [4:0]  hi_sum;
   logic        lo_carry;
   logic        hi_carry;
   logic [3:0]  lo_digit;
   logic [3:0]  hi_digit;
   logic [8:0]  add_sum;
   logic [8:0]  sub_diff;
   logic [15:0] product;
   logic [7:0]  bit_mask;

   // Decimal add: correct each nibble by six when it passes nine
   assign lo_sum   = {1'b0, req.operand_a[3:0]} + {1'b0, req.operand_b[3:0]}
                     + {4'd0, req.carry_in};
   assign lo_carry = lo_sum > {1'b0, BCD_MAX_DIGIT};
   assign hi_sum   = {1'b0, req.operand_a[7:4]} + {1'b0, req.operand_b[7:4]}
                     + {4'd0, lo_carry};
   assign hi_carry = hi_sum > {1'b0, BCD_MAX_DIGIT};
   assign lo_digit = lo_carry ? lo_sum[3:0] + BCD_ADJUST : lo_sum[3:0];
   assign hi_digit = hi_carry ? hi_sum[3:0] + BCD_ADJUST : hi_sum[3:0];

   // Binary add and subtract with borrow
   assign add_sum  = {1'b0, req.operand_a} + {1'b0, req.operand_b}
                     + {8'd0, req.carry_in};
   assign sub_diff = {1'b0, req.operand_a} - {1'b0, req.operand_b}
                     - {8'd0, ~req.carry_in};

   assign product  = {8'd0, req.operand_a} * {8'd0, req.operand_b};
   assign bit_mask = 8'd1 << req.bit_index;

   // Pick the result and flags of the operation
   always_comb begin
      stage     = '0;
      stage.op  = req.op;
      stage.b   = req.operand_b;
      stage.r   = req.operand_a;
      stage.c   = req.carry_in;
      stage.v   = req.overflow_in;
      stage.wnz = 1'b1;
      stage.num = {req.dividend_high, req.operand_a};
      stage.rem = 8'd0;
      case (req.op)
         OP_OR:  stage.r = req.operand_a | req.operand_b;
         OP_AND: stage.r = req.operand_a & req.operand_b;
         OP_XOR: stage.r = req.operand_a ^ req.operand_b;
         OP_ADC: begin
            if (req.decimal_mode) begin
               stage.r = {hi_digit, lo_digit};
               stage.c = hi_carry;
            end else begin
               stage.r = add_sum[7:0];
               stage.c = add_sum[8];
               stage.v = ~(req.operand_a[7] ^ req.operand_b[7])
                         & (req.operand_a[7] ^ add_sum[7]);
            end
         end
         OP_SBC: begin
            stage.r = sub_diff[7:0];
            stage.c = ~sub_diff[8];
            stage.v = (req.operand_a[7] ^ req.operand_b[7])
                      & (req.operand_a[7] ^ sub_diff[7]);
         end
         OP_CMP: stage.c = req.operand_a >= req.operand_b;
         OP_BIT: begin
            stage.n = req.operand_b[7];
            stage.z = (req.operand_a & req.operand_b) == 8'd0;
            stage.v = req.operand_b[6];
         end
         OP_ASL: begin
            stage.c = req.operand_a[7];
            stage.r = {req.operand_a[6:0], 1'b0};
         end
         OP_LSR: begin
            stage.c = req.operand_a[0];
            stage.r = {1'b0, req.operand_a[7:1]};
         end
         OP_ROL: begin
            stage.c = req.operand_a[7];
            stage.r = {req.operand_a[6:0], req.carry_in};
         end
         OP_ROR: begin
            stage.c = req.operand_a[0];
            stage.r = {req.carry_in, req.operand_a[7:1]};
         end
         OP_INC: stage.r = req.operand_a + 8'd1;
         OP_DEC: stage.r = req.operand_a - 8'd1;
         OP_SWAP: begin
            stage.r   = {req.operand_a[3:0], req.operand_a[7:4]};
            stage.wnz = 1'b0;
         end
         OP_MUL: begin
            stage.r  = product[7:0];
            stage.hi = product[15:8];
         end
         OP_DIV: stage.r = req.operand_a;
         OP_SETBIT: begin
            stage.r   = req.operand_a | bit_mask;
            stage.wnz = 1'b0;
         end
         OP_CLRBIT: begin
            stage.r   = req.operand_a & ~bit_mask;
            stage.wnz = 1'b0;
         end
         OP_TEST: stage.r = req.operand_a;
         default: stage.wnz = 1'b0;
      endcase
      // N and Z follow the difference for compare, the result otherwise
      stage.nzv = (req.op == OP_CMP) ? sub_diff[7:0] + {7'd0, ~req.carry_in}
                                     : stage.r;
   end

endmodule

[hdl/acc_div_stage.sv]
// One registered stage of the restoring divider: works STEPS quotient bits
// and carries the rest of the word along. Depends on acc_pkg.
module acc_div_stage #(
   parameter int STEPS = acc_pkg::DIV_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  acc_pkg::stage_type in_stage,
   output logic               out_valid,
   output acc_pkg::stage_type out_stage
);
   import acc_pkg::*;

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in;

   // Shift in one dividend bit per step, subtract the divisor when it fits
   always_comb begin : div_steps
      logic [8:0]  part;
      logic [7:0]  rem;
      logic [15:0] num;
      rem      = in_stage.rem;
      num      = in_stage.num;
      part     = '0;
      stage_in = in_stage;
      for (int i = 0; i < STEPS; i++) begin
         part = {rem, num[15]};
         num  = {num[14:0], 1'b0};
         if (part >= {1'b0, in_stage.b}) begin
            part   = part - {1'b0, in_stage.b};
            num[0] = 1'b1;
         end
         rem = part[7:0];
      end
      stage_in.rem = rem;
      stage_in.num = num;
   end

   // Advance the word; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[hdl/accumulator_alu_with_bcd_mul_div.sv]
// Top level of the 8-bit accumulator ALU with decimal add, multiply and divide.
// Instantiates acc_front and acc_div_stage; depends on acc_pkg.
//
//   channel   ports                     handshake
//   --------  ------------------------  ---------------------------------
//   request   start, busy, req_data     taken when start high, busy low
//   response  rsp_valid, rsp_data       one-cycle strobe, no back-pressure
//
// One operation can enter every cycle while busy is low. Each word taken
// passes the request register, the front end, every divider stage (four
// quotient bits a stage by default) and the response register, divide or not.
// busy is high only while reset is applied and for the cycle after it.
// Reset clears the valid bits of every stage; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module accumulator_alu_with_bcd_mul_div #(
   parameter int DIV_STEPS_PER_STAGE = acc_pkg::DIV_STEPS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  acc_pkg::req_type req_data,
   output logic             rsp_valid,
   output acc_pkg::rsp_type rsp_data
);
   import acc_pkg::*;

   localparam int DIV_STAGES = DIV_BITS / DIV_STEPS_PER_STAGE;

   logic      busy_ff;
   logic      req_valid_ff;
   req_type   req_ff;
   logic      stage_valid [0:DIV_STAGES];
   stage_type stage_data  [0:DIV_STAGES];
   stage_type last;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic [7:0] nzv;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start & ~busy_ff;
      end
      req_ff <= req_data;
   end

   assign busy = busy_ff;

   acc_front u_front (
      .req   (req_ff),
      .stage (stage_data[0])
   );

   assign stage_valid[0] = req_valid_ff;

   // Chain of divider stages
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      acc_div_stage #(
         .STEPS (DIV_STEPS_PER_STAGE)
      ) u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_stage  (stage_data[g]),
         .out_valid (stage_valid[g + 1]),
         .out_stage (stage_data[g + 1])
      );
   end

   assign last = stage_data[DIV_STAGES];

   // Finish divide results and work N and Z
   always_comb begin
      rsp_in                = '0;
      rsp_in.result         = last.r;
      rsp_in.result_high    = last.hi;
      rsp_in.carry_out      = last.c;
      rsp_in.overflow_out   = last.v;
      rsp_in.writes_nz      = last.wnz;
      nzv                   = last.nzv;
      if (last.op == OP_DIV) begin
         if (last.b == 8'd0) begin
            rsp_in.divide_by_zero = 1'b1;
         end else begin
            rsp_in.result      = last.num[7:0];
            rsp_in.result_high = last.rem;
            nzv                = last.num[7:0];
         end
      end
      if (last.op == OP_BIT) begin
         rsp_in.negative = last.n;
         rsp_in.zero     = last.z;
      end else if (last.wnz) begin
         rsp_in.negative = nzv[7];
         rsp_in.zero     = nzv == 8'd0;
      end
   end

   // Hold the response for its one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid[DIV_STAGES];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/acc_checker.sv]
// Port-level checker for the accumulator ALU, bound to the top level.
// Depends on acc_pkg and on the top level's ports.
module acc_checker #(
   parameter int DIV_STEPS = acc_pkg::DIV_STEPS_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input acc_pkg::rsp_type rsp_data
);
   import acc_pkg::*;

   localparam int LATENCY = 2 + DIV_BITS / DIV_STEPS;

   // Every word taken comes out after the fixed latency
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word did not produce a response");

   // No response without a word taken the latency earlier
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response without a matching request");

   // Divide by zero returns no remainder and still writes N and Z
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_by_zero)
         |-> (rsp_data.result_high == 8'd0 && rsp_data.writes_nz))
      else $error("divide by zero response malformed");

   // N and Z stay clear when they are not written
   a_nz_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.writes_nz)
         |-> (!rsp_data.negative && !rsp_data.zero))
      else $error("N or Z set on a response that does not write them");

endmodule

bind accumulator_alu_with_bcd_mul_div acc_checker #(
   .DIV_STEPS (DIV_STEPS_PER_STAGE)
) u_acc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for accumulator_alu_with_bcd_mul_div: a directed table,
// then random words, each checked against a typed result or the ALU predictor.
// Depends on acc_pkg and the accumulator_alu_with_bcd_mul_div RTL.
module tb_top;
   import acc_pkg::*;

   // Op codes above OP_TEST do nothing
   localparam logic [4:0] OP_FIRST_UNUSED = 5'd19;
   localparam logic [4:0] OP_LAST_CODE    = 5'd31;
   localparam int         RANDOM_WORDS    = 1600;
   localparam int         DRAIN_CYCLES    = 32;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type pending_results[$];
   int      error_count = 0;

   // Directed table: words, expected results and whether one was typed in
   req_type dir_words[$];
   rsp_type dir_wants[$];
   bit      dir_typed[$];

   accumulator_alu_with_bcd_mul_div DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up after far longer than the slowest correct run
   initial begin
      #3000000;
      $display("accumulator_alu_with_bcd_mul_div test failed");
      $finish;
   end

   // Work out the result word the ALU should give for one request word
   function automatic rsp_type alu_outcome(input req_type w);
      rsp_type     o;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  nz_src;
      logic [5:0]  lo_dig;
      logic [5:0]  hi_dig;
      logic [8:0]  sum;
      logic [15:0] wide;
      logic [15:0] num;
      a = w.operand_a;
      b = w.operand_b;
      o = '0;
      o.result       = a;
      o.carry_out    = w.carry_in;
      o.overflow_out = w.overflow_in;
      o.writes_nz    = 1'b1;
      nz_src         = a;
      case (w.op)
         OP_OR:  o.result = a | b;
         OP_AND: o.result = a & b;
         OP_XOR: o.result = a ^ b;
         OP_ADC: begin
            if (w.decimal_mode) begin
               // correct each digit by six once it passes nine; V is left alone
               lo_dig = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'd0, w.carry_in};
               hi_dig = {2'b00, a[7:4]} + {2'b00, b[7:4]}
                        + {5'd0, (lo_dig > {2'b00, BCD_MAX_DIGIT})};
               if (lo_dig > {2'b00, BCD_MAX_DIGIT}) lo_dig = lo_dig + {2'b00, BCD_ADJUST};
               if (hi_dig > {2'b00, BCD_MAX_DIGIT}) hi_dig = hi_dig + {2'b00, BCD_ADJUST};
               o.carry_out = (hi_dig > {2'b00, BCD_MAX_DIGIT});
               o.result    = {hi_dig[3:0], lo_dig[3:0]};
            end else begin
               sum            = {1'b0, a} + {1'b0, b} + {8'd0, w.carry_in};
               o.carry_out    = sum[8];
               o.overflow_out = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
               o.result       = sum[7:0];
            end
         end
         OP_SBC: begin
            // binary even in decimal mode; carry means no borrow
            wide           = {8'h00, a} - {8'h00, b} - {15'd0, ~w.carry_in};
            o.carry_out    = (wide[15:8] == 8'h00);
            o.overflow_out = (a[7] ^ b[7]) & (a[7] ^ wide[7]);
            o.result       = wide[7:0];
         end
         OP_CMP: begin
            o.carry_out = (a >= b);
            nz_src      = a - b;
         end
         OP_BIT: o.overflow_out = b[6];
         OP_ASL: begin
            o.carry_out = a[7];
            o.result    = {a[6:0], 1'b0};
         end
         OP_LSR: begin
            o.carry_out = a[0];
            o.result    = {1'b0, a[7:1]};
         end
         OP_ROL: begin
            o.carry_out = a[7];
            o.result    = {a[6:0], w.carry_in};
         end
         OP_ROR: begin
            o.carry_out = a[0];
            o.result    = {w.carry_in, a[7:1]};
         end
         OP_INC: o.result = a + 8'd1;
         OP_DEC: o.result = a - 8'd1;
         OP_SWAP: begin
            o.result    = {a[3:0], a[7:4]};
            o.writes_nz = 1'b0;
         end
         OP_MUL: begin
            wide          = {8'h00, a} * {8'h00, b};
            o.result      = wide[7:0];
            o.result_high = wide[15:8];
         end
         OP_DIV: begin
            if (b != 8'h00) begin
               num           = {w.dividend_high, a};
               wide          = num / {8'h00, b};
               o.result      = wide[7:0];
               wide          = num % {8'h00, b};
               o.result_high = wide[7:0];
            end else begin
               o.divide_by_zero = 1'b1;
            end
         end
         OP_SETBIT: begin
            o.result    = a | (8'h01 << w.bit_index);
            o.writes_nz = 1'b0;
         end
         OP_CLRBIT: begin
            o.result    = a & ~(8'h01 << w.bit_index);
            o.writes_nz = 1'b0;
         end
         OP_TEST: o.result = a;
         default: o.writes_nz = 1'b0;
      endcase
      if (w.op != OP_CMP) nz_src = o.result;
      // take N and Z from the tested value, or from the operands for bit test
      if (o.writes_nz) begin
         if (w.op == OP_BIT) begin
            o.negative = b[7];
            o.zero     = ((a & b) == 8'h00);
         end else begin
            o.negative = nz_src[7];
            o.zero     = (nz_src == 8'h00);
         end
      end
      return o;
   endfunction

   function automatic req_type mk_req(input logic [4:0] op, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] dh,
                                      input logic [2:0] bi, input logic cin,
                                      input logic vin, input logic dec);
      req_type w;
      w.op            = op;
      w.operand_a     = a;
      w.operand_b     = b;
      w.dividend_high = dh;
      w.bit_index     = bi;
      w.carry_in      = cin;
      w.overflow_in   = vin;
      w.decimal_mode  = dec;
      return w;
   endfunction

   function automatic rsp_type mk_rsp(input logic [7:0] r, input logic [7:0] hi,
                                      input logic n, input logic z, input logic c,
                                      input logic v, input logic wnz, input logic dz);
      rsp_type o;
      o.result         = r;
      o.result_high    = hi;
      o.negative       = n;
      o.zero           = z;
      o.carry_out      = c;
      o.overflow_out   = v;
      o.writes_nz      = wnz;
      o.divide_by_zero = dz;
      return o;
   endfunction

   function automatic logic [7:0] corner_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'h7F;
         2:       return 8'h80;
         default: return 8'hFF;
      endcase
   endfunction

   task automatic row_typed(input req_type w, input rsp_type want);
      dir_words.push_back(w);
      dir_wants.push_back(want);
      dir_typed.push_back(1'b1);
   endtask

   task automatic row_predicted(input req_type w);
      dir_words.push_back(w);
      dir_wants.push_back('0);
      dir_typed.push_back(1'b0);
   endtask

   // Idle with start low over the gap, then hold the word until the ALU takes it
   task automatic drive_word(input req_type w, input rsp_type want, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      pending_results.push_back(want);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Compare each result word with the oldest outstanding one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result word 0x%0h with none outstanding", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result", want.result, rsp_data.result);
            check_field("result_high", want.result_high, rsp_data.result_high);
            check_field("negative", want.negative, rsp_data.negative);
            check_field("zero", want.zero, rsp_data.zero);
            check_field("carry_out", want.carry_out, rsp_data.carry_out);
            check_field("overflow_out", want.overflow_out, rsp_data.overflow_out);
            check_field("writes_nz", want.writes_nz, rsp_data.writes_nz);
            check_field("divide_by_zero", want.divide_by_zero, rsp_data.divide_by_zero);
         end
      end
   end

   initial begin
      req_type word;
      int      gap;
      bit      quiet;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      // Directed table:  op  a  b  dh  bit  C  V  D
      row_typed(mk_req(OP_OR, 8'h00, 8'h00, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h00, 8'h00, 0, 1, 0, 0, 1, 0));
      row_typed(mk_req(OP_AND, 8'hFF, 8'hFF, 8'h00, 3'd0, 1, 1, 0),
                mk_rsp(8'hFF, 8'h00, 1, 0, 1, 1, 1, 0));
      row_typed(mk_req(OP_XOR, 8'hFF, 8'hFF, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h00, 8'h00, 0, 1, 0, 0, 1, 0));
      row_typed(mk_req(OP_ADC, 8'hFF, 8'h01, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h00, 8'h00, 0, 1, 1, 0, 1, 0));
      row_typed(mk_req(OP_ADC, 8'h7F, 8'h01, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h80, 8'h00, 1, 0, 0, 1, 1, 0));
      // decimal add: both digits wrap past nine
      row_typed(mk_req(OP_ADC, 8'h99, 8'h01, 8'h00, 3'd0, 0, 0, 1),
                mk_rsp(8'h00, 8'h00, 0, 1, 1, 0, 1, 0));
      row_predicted(mk_req(OP_ADC, 8'h45, 8'h38, 8'h00, 3'd0, 1, 1, 1));
      row_typed(mk_req(OP_SBC, 8'h00, 8'h01, 8'h00, 3'd0, 1, 0, 0),
                mk_rsp(8'hFF, 8'h00, 1, 0, 0, 0, 1, 0));
      row_predicted(mk_req(OP_SBC, 8'h80, 8'h01, 8'h00, 3'd0, 1, 0, 0));
      // subtract in decimal mode stays binary
      row_typed(mk_req(OP_SBC, 8'h10, 8'h01, 8'h00, 3'd0, 1, 0, 1),
                mk_rsp(8'h0F, 8'h00, 0, 0, 1, 0, 1, 0));
      row_typed(mk_req(OP_CMP, 8'h40, 8'h40, 8'h00, 3'd0, 0, 1, 0),
                mk_rsp(8'h40, 8'h00, 0, 1, 1, 1, 1, 0));
      row_typed(mk_req(OP_BIT, 8'h0F, 8'hC0, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h0F, 8'h00, 1, 1, 0, 1, 1, 0));
      row_typed(mk_req(OP_ASL, 8'h80, 8'h00, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h00, 8'h00, 0, 1, 1, 0, 1, 0));
      row_predicted(mk_req(OP_LSR, 8'h01, 8'h00, 8'h00, 3'd0, 0, 0, 0));
      row_predicted(mk_req(OP_ROL, 8'h80, 8'h00, 8'h00, 3'd0, 1, 0, 0));
      row_predicted(mk_req(OP_ROR, 8'h01, 8'h00, 8'h00, 3'd0, 1, 0, 0));
      row_typed(mk_req(OP_INC, 8'hFF, 8'h00, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h00, 8'h00, 0, 1, 0, 0, 1, 0));
      row_typed(mk_req(OP_DEC, 8'h00, 8'h00, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'hFF, 8'h00, 1, 0, 0, 0, 1, 0));
      row_typed(mk_req(OP_SWAP, 8'hA5, 8'h00, 8'h00, 3'd0, 1, 1, 0),
                mk_rsp(8'h5A, 8'h00, 0, 0, 1, 1, 0, 0));
      row_typed(mk_req(OP_MUL, 8'hFF, 8'hFF, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h01, 8'hFE, 0, 0, 0, 0, 1, 0));
      // quotient wider than a byte is cut to its low byte
      row_typed(mk_req(OP_DIV, 8'hFF, 8'h01, 8'hFF, 3'd0, 0, 0, 0),
                mk_rsp(8'hFF, 8'h00, 1, 0, 0, 0, 1, 0));
      // divide by zero keeps A and flags the word
      row_typed(mk_req(OP_DIV, 8'h3C, 8'h00, 8'h12, 3'd0, 1, 0, 0),
                mk_rsp(8'h3C, 8'h00, 0, 0, 1, 0, 1, 1));
      row_typed(mk_req(OP_SETBIT, 8'h00, 8'h00, 8'h00, 3'd7, 0, 0, 0),
                mk_rsp(8'h80, 8'h00, 0, 0, 0, 0, 0, 0));
      row_typed(mk_req(OP_CLRBIT, 8'hFF, 8'h00, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'hFE, 8'h00, 0, 0, 0, 0, 0, 0));
      row_typed(mk_req(OP_TEST, 8'h00, 8'h00, 8'h00, 3'd0, 0, 0, 0),
                mk_rsp(8'h00, 8'h00, 0, 1, 0, 0, 1, 0));
      // unused op code: no operation, flags pass through
      row_typed(mk_req(OP_LAST_CODE, 8'h77, 8'h00, 8'h00, 3'd0, 1, 1, 0),
                mk_rsp(8'h77, 8'h00, 0, 0, 1, 1, 0, 0));

      // Hold reset, then release it once
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_words[i]) begin
         if (dir_typed[i]) drive_word(dir_words[i], dir_wants[i], $urandom_range(0, 6));
         else drive_word(dir_words[i], alu_outcome(dir_words[i]), $urandom_range(0, 6));
      end

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 9) == 0)
            word.op = 5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
         else word.op = 5'($urandom_range(OP_OR, OP_TEST));
         word.operand_a     = 8'($urandom);
         word.operand_b     = 8'($urandom);
         word.dividend_high = 8'($urandom);
         word.bit_index     = 3'($urandom);
         word.carry_in      = 1'($urandom);
         word.overflow_in   = 1'($urandom);
         word.decimal_mode  = 1'($urandom);
         if ($urandom_range(0, 3) == 0) word.operand_a = corner_byte();
         if ($urandom_range(0, 3) == 0) word.operand_b = corner_byte();
         // favour valid BCD digits for decimal add
         if (word.op == OP_ADC && word.decimal_mode && $urandom_range(0, 2) != 0) begin
            word.operand_a = 8'(($urandom_range(0, 9) << 4) | $urandom_range(0, 9));
            word.operand_b = 8'(($urandom_range(0, 9) << 4) | $urandom_range(0, 9));
         end
         // mix zero divisors, in-range quotients and overflowing ones
         if (word.op == OP_DIV) begin
            case ($urandom_range(0, 7))
               0: word.operand_b = 8'h00;
               1, 2, 3, 4: if (word.operand_b != 8'h00)
                  word.dividend_high = 8'($urandom % word.operand_b);
               default: ;
            endcase
         end
         // halfway, hold off until every outstanding result has arrived
         if (i == RANDOM_WORDS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end
         quiet = ((i / 200) % 3 == 2);
         gap   = quiet ? 0 : $urandom_range(0, 6);
         drive_word(word, alu_outcome(word), gap);
      end

      // Drop start, drain the pipeline, then allow for its latency
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("accumulator_alu_with_bcd_mul_div test passed");
      else $display("accumulator_alu_with_bcd_mul_div test failed");
      $finish;
   end

endmodule

[accumulator_alu_with_bcd_mul_div.f]
hdl/acc_pkg.sv
hdl/acc_front.sv
hdl/acc_div_stage.sv
hdl/accumulator_alu_with_bcd_mul_div.sv
hdl/acc_checker.sv
tb/sv/tb_top.sv
